/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files; the parser includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define HCBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hcbd assertion failed");

// Checked at every clock edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("hcbd assertion failed");

`endif

/* hw/rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared types, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned BodyLenW = 24;
  localparam int unsigned TotExtW  = 32;

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  typedef enum logic [2:0] {
    PH_SIZE       = 3'd0,
    PH_DATA       = 3'd1,
    PH_AFTER_DATA = 3'd2,
    PH_AFTER_CR   = 3'd3,
    PH_DONE       = 3'd4,
    PH_ERROR      = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_body;
  } item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                is_data;
    logic                body_done;
    logic [BodyLenW-1:0] body_length;
    logic                length_error;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

/* hw/rtl/hcbd_if.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder channels
// Valid/ready channels for raw body bytes and for decoded results.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_body;

  modport source (output valid, output in_byte, output start_of_body, input ready);
  modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_data;
  logic        body_done;
  logic [23:0] body_length;
  logic        length_error;

  modport source (output valid, output out_byte, output is_data, output body_done,
                  output body_length, output length_error, input ready);
  modport sink   (input valid, input out_byte, input is_data, input body_done,
                  input body_length, input length_error, output ready);
endinterface

/* hw/rtl/hcbd_in_stage.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder input stage
// Registers one incoming byte and hands it to the parser.
// ----------------------------------------------------------------------------
module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_ready_i
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  in_fire;

  assign in_i.ready = !valid_q || item_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.in_byte       <= in_i.in_byte;
      item_q.start_of_body <= in_i.start_of_body;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* hw/rtl/hcbd_parser.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder parser
// Holds the parse state and decodes one registered byte per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbd_parser
  import hcbd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned TOTAL_BITS  = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e                 ph_q, ph_d, ph_e;
  logic [LENGTH_BITS-1:0] rem_q, rem_d, rem_e, rem_s;
  logic [TOTAL_BITS-1:0]  tot_q, tot_d, tot_e;
  logic                   snh_q, snh_d, snh_e, snh_s;
  logic                   do_size;
  logic [7:0]             c;
  hex_t                   hx;
  logic [TotExtW-1:0]     tot_ext;

  assign c  = item_i.in_byte;
  assign hx = hex_decode(c);

  // A start mark restarts the parser before the byte is taken.
  always_comb begin
    if (item_i.start_of_body) begin
      ph_e  = PH_SIZE;
      rem_e = '0;
      tot_e = '0;
      snh_e = 1'b0;
    end else begin
      ph_e  = ph_q;
      rem_e = rem_q;
      tot_e = tot_q;
      snh_e = snh_q;
    end
  end

  assign tot_ext = TotExtW'(tot_e);
  assign rem_s   = (ph_e == PH_SIZE) ? rem_e : '0;
  assign snh_s   = (ph_e == PH_SIZE) ? snh_e : 1'b0;

  always_comb begin
    ph_d        = ph_e;
    rem_d       = rem_e;
    tot_d       = tot_e;
    snh_d       = snh_e;
    do_size     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (ph_e)
      PH_SIZE: begin
        do_size = 1'b1;
      end
      PH_DATA: begin
        if (!(&tot_e)) begin
          tot_d = tot_e + TOTAL_BITS'(1);
        end
        if (rem_e != '0) begin
          rem_d = rem_e - LENGTH_BITS'(1);
        end
        if (rem_e <= LENGTH_BITS'(1)) begin
          ph_d = PH_AFTER_DATA;
        end
        res_valid_o    = 1'b1;
        res_o.out_byte = c;
        res_o.is_data  = 1'b1;
      end
      PH_AFTER_DATA: begin
        rem_d = '0;
        snh_d = 1'b0;
        if (c == CharCr) begin
          ph_d = PH_AFTER_CR;
        end else begin
          ph_d    = PH_SIZE;
          do_size = (c != CharLf);
        end
      end
      PH_AFTER_CR: begin
        ph_d    = PH_SIZE;
        do_size = (c != CharLf);
      end
      default: begin
      end
    endcase

    if (do_size) begin
      rem_d = rem_s;
      snh_d = snh_s;
      if (c == CharLf) begin
        snh_d = 1'b0;
        if (rem_s == '0) begin
          ph_d              = PH_DONE;
          res_valid_o       = 1'b1;
          res_o.body_done   = 1'b1;
          res_o.body_length = tot_ext[BodyLenW-1:0];
        end else begin
          ph_d = PH_DATA;
        end
      end else if (!snh_s) begin
        if (!hx.valid) begin
          snh_d = 1'b1;
        end else if (rem_s[LENGTH_BITS-1 -: 4] != 4'd0) begin
          ph_d               = PH_ERROR;
          res_valid_o        = 1'b1;
          res_o.length_error = 1'b1;
          res_o.body_length  = tot_ext[BodyLenW-1:0];
        end else begin
          rem_d = {rem_s[LENGTH_BITS-5:0], hx.value};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_SIZE;
      rem_q <= '0;
      tot_q <= '0;
      snh_q <= 1'b0;
    end else if (adv_i) begin
      ph_q  <= ph_d;
      rem_q <= rem_d;
      tot_q <= tot_d;
      snh_q <= snh_d;
    end
  end

  `HCBD_ASSERT(a_data_has_bytes_left, (ph_q == PH_DATA) |-> (rem_q != '0))
  `HCBD_ASSERT(a_done_enters_done,
               (adv_i && res_valid_o && res_o.body_done) |=> (ph_q == PH_DONE))
  `HCBD_ASSERT(a_error_enters_error,
               (adv_i && res_valid_o && res_o.length_error) |=> (ph_q == PH_ERROR))
  `HCBD_ASSERT(a_data_counts,
               (adv_i && ph_q == PH_DATA && !item_i.start_of_body) |=>
               ((tot_q != $past(tot_q)) || (&tot_q)))

endmodule

/* hw/rtl/hcbd_out_stage.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder output stage
// Result register that holds one decoded result until it is taken.
// ----------------------------------------------------------------------------
module hcbd_out_stage
  import hcbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  logic        res_valid_i,
  input  result_t     res_i,
  hcbd_out_if.source  out_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign item_ready_o = !valid_q || out_o.ready;
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = res_valid_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.is_data      = res_q.is_data;
  assign out_o.body_done    = res_q.body_done;
  assign out_o.body_length  = res_q.body_length;
  assign out_o.length_error = res_q.length_error;

endmodule

/* hw/rtl/http_chunked_body_decoder_unit.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Decodes a chunked HTTP body byte by byte and passes out the payload bytes.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                            Transfer
// in_i     in   in_byte, start_of_body                             one raw byte
// out_o    out  out_byte, is_data, body_done, body_length,         one result
//               length_error
//
// One byte is accepted per cycle while the output is not stalled; each byte is registered
// in the input register, and the parser decodes it combinationally into the result register;
// the parser state updates in the same cycle as the result register loads.
// Reset is asynchronous and leaves the parser at the start of a size line.
// A stalled output holds the result register and the input register; the input
// then takes at most one more byte before it stalls too.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned TOTAL_BITS  = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    res_valid;
  result_t res;

  hcbd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  hcbd_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (item_valid && item_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hcbd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .out_o        (out_o)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder testbench
// Drives chunked bodies into the decoder with random gaps and output stalls,
// predicts every result with an independent parser and checks each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hcbd_pkg::*;

  localparam int unsigned SizeW      = 32;
  localparam int          IdleLimit  = 2000;
  localparam int          DrainExtra = 4;
  localparam int          MaxReports = 10;

  logic clk_i;
  logic rst_ni;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  phase_e              parse_ph      = PH_SIZE;
  logic [SizeW-1:0]    size_left     = '0;
  logic [BodyLenW-1:0] payload_total = '0;
  bit                  size_nonhex   = 1'b0;

  result_t expected_q[$];
  result_t got_r;
  result_t exp_r;
  int      live_items     = 0;
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      hold_cycles    = 0;
  bit      tx_gaps        = 1'b1;
  bit      rx_stalls      = 1'b1;
  bit      new_body       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
  endfunction

  function automatic void size_line_byte(input logic [7:0] c, output bit emit,
                                         output result_t r);
    logic [4:0] d;
    emit = 1'b0;
    r    = '0;
    if (c == CharLf) begin
      size_nonhex = 1'b0;
      if (size_left == '0) begin
        parse_ph      = PH_DONE;
        emit          = 1'b1;
        r.body_done   = 1'b1;
        r.body_length = payload_total;
      end else begin
        parse_ph = PH_DATA;
      end
    end else if (!size_nonhex) begin
      d = hex_digit(c);
      if (!d[4]) begin
        size_nonhex = 1'b1;
      end else if (size_left[SizeW-1 -: 4] != 4'd0) begin
        parse_ph       = PH_ERROR;
        emit           = 1'b1;
        r.length_error = 1'b1;
        r.body_length  = payload_total;
      end else begin
        size_left = {size_left[SizeW-5:0], d[3:0]};
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input bit sob,
                                      output bit emit, output result_t r);
    emit = 1'b0;
    r    = '0;
    if (sob) begin
      parse_ph      = PH_SIZE;
      size_left     = '0;
      payload_total = '0;
      size_nonhex   = 1'b0;
    end
    if (parse_ph != PH_DONE && parse_ph != PH_ERROR) live_items++;
    case (parse_ph)
      PH_SIZE: size_line_byte(c, emit, r);
      PH_DATA: begin
        if (payload_total != '1) payload_total++;
        if (size_left != '0) size_left--;
        if (size_left == '0) parse_ph = PH_AFTER_DATA;
        emit       = 1'b1;
        r.out_byte = c;
        r.is_data  = 1'b1;
      end
      PH_AFTER_DATA: begin
        size_left   = '0;
        size_nonhex = 1'b0;
        if (c == CharCr) begin
          parse_ph = PH_AFTER_CR;
        end else begin
          parse_ph = PH_SIZE;
          if (c != CharLf) size_line_byte(c, emit, r);
        end
      end
      PH_AFTER_CR: begin
        parse_ph = PH_SIZE;
        if (c != CharLf) size_line_byte(c, emit, r);
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int      gap;
    bit      emit;
    result_t r;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.in_byte       = b;
    in_if.start_of_body = new_body;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, new_body, emit, r);
    if (emit) expected_q.push_back(r);
    new_body = 1'b0;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_size_line(input logic [SizeW-1:0] size);
    bit         started;
    logic [7:0] b;
    started = 1'b0;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_byte("0");
    for (int k = SizeW / 4 - 1; k >= 0; k--) begin
      if (size[4*k +: 4] != 4'd0 || started || k == 0) begin
        send_byte(hex_char(size[4*k +: 4]));
        started = 1'b1;
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      send_byte(";");
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CharLf) b = " ";
        send_byte(b);
      end
    end
    if ($urandom_range(0, 3) != 0) send_byte(CharCr);
    send_byte(CharLf);
  endtask

  task automatic send_body();
    int unsigned size;
    int          r;
    new_body = 1'b1;
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 19);
      if (r == 0) size = $urandom_range(65, 300);
      else if (r < 5) size = $urandom_range(17, 64);
      else size = $urandom_range(1, 16);
      send_size_line(size);
      repeat (size) send_byte(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_byte(CharCr);
        send_byte(CharLf);
      end else if (r == 7) begin
        send_byte(CharLf);
      end else if (r == 8) begin
        send_byte(CharCr);
      end
    end
    r = $urandom_range(0, 5);
    if (r == 0) send_byte(CharLf);
    else if (r == 1) send_text("x\r\n");
    else send_size_line(0);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_oversized_size();
    new_body = 1'b1;
    send_byte(hex_char(4'($urandom_range(1, 15))));
    repeat ($urandom_range(8, 11)) send_byte(hex_char(4'($urandom_range(0, 15))));
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    new_body = 1'b1;
    repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainExtra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_basic_chunks();
    new_body = 1'b1;
    send_text("2\r\n");
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("\r\n0\n");
  endtask

  task automatic test_size_line_quirks();
    new_body = 1'b1;
    send_text("0x1\n");
    new_body = 1'b1;
    send_text(" 5\n");
    new_body = 1'b1;
    send_text("\n");
  endtask

  task automatic test_size_overflow();
    new_body = 1'b1;
    send_text("FFFFFFFFa");
  endtask

  task automatic test_random_bodies(input int target);
    int first;
    int k;
    first = live_items;
    while (live_items - first < target) begin
      k = $urandom_range(0, 9);
      if (k == 0) send_noise();
      else if (k == 1) send_oversized_size();
      else send_body();
    end
  endtask

  task automatic test_output_hold_off();
    tx_gaps     = 1'b0;
    hold_cycles = 300;
    new_body    = 1'b1;
    send_size_line(64);
    repeat (64) send_byte(8'($urandom_range(0, 255)));
    send_text("\r\n40\r\n");
    repeat (64) send_byte(8'($urandom_range(0, 255)));
    send_text("\r\n0\r\n");
    tx_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    test_random_bodies(150);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (5) begin
      send_body();
      wait_drain();
    end
  endtask

  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else if (!rx_stalls) begin
        out_if.ready = 1'b1;
      end else begin
        stall        = pick_gap();
        out_if.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_r.out_byte     = out_if.out_byte;
      got_r.is_data      = out_if.is_data;
      got_r.body_done    = out_if.body_done;
      got_r.body_length  = out_if.body_length;
      got_r.length_error = out_if.length_error;
      if (expected_q.size() == 0) begin
        if (mismatch_count < MaxReports) begin
          $display("unexpected result: byte=%h data=%b done=%b len=%0d err=%b",
                   got_r.out_byte, got_r.is_data, got_r.body_done,
                   got_r.body_length, got_r.length_error);
        end
        mismatch_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got_r.out_byte !== exp_r.out_byte || got_r.is_data !== exp_r.is_data ||
            got_r.body_done !== exp_r.body_done ||
            got_r.body_length !== exp_r.body_length ||
            got_r.length_error !== exp_r.length_error) begin
          if (mismatch_count < MaxReports) begin
            $display("mismatch: expected byte=%h data=%b done=%b len=%0d err=%b",
                     exp_r.out_byte, exp_r.is_data, exp_r.body_done,
                     exp_r.body_length, exp_r.length_error);
            $display("          actual   byte=%h data=%b done=%b len=%0d err=%b",
                     got_r.out_byte, got_r.is_data, got_r.body_done,
                     got_r.body_length, got_r.length_error);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    in_if.start_of_body = 1'b0;
    rst_ni              = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_chunks();
    test_size_line_quirks();
    test_size_overflow();
    test_random_bodies(600);
    test_output_hold_off();
    test_full_rate();
    test_pause_until_drained();
    test_random_bodies(550);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_if.sv
hw/rtl/hcbd_in_stage.sv
hw/rtl/hcbd_parser.sv
hw/rtl/hcbd_out_stage.sv
hw/rtl/http_chunked_body_decoder_unit.sv
tb/testbench.sv
